### sv/spv_pkg.sv
// Shared types and constants for the STUN packet validator.
package spv_pkg;

    localparam int unsigned COUNT_W = 17;
    localparam int unsigned LEN_W = 16;
    localparam logic [COUNT_W-1:0] HDR_BYTES = 17'd20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [31:0] MAGIC_COOKIE = 32'h2112A442;
    localparam logic [COUNT_W-1:0] IDX_LEN_HI = 17'd2;
    localparam logic [COUNT_W-1:0] IDX_LEN_LO = 17'd3;
    localparam logic [COUNT_W-1:0] IDX_COOKIE_FIRST = 17'd4;
    localparam logic [COUNT_W-1:0] IDX_COOKIE_END = 17'd8;
    localparam logic [COUNT_W-1:0] ATTR_HDR_BYTES = 17'd4;

    typedef enum logic [2:0] {
        REASON_OK = 3'd0,
        REASON_SHORT = 3'd1,
        REASON_BAD_COOKIE = 3'd2,
        REASON_LEN_OVERRUN = 3'd3,
        REASON_ATTR_TRUNC = 3'd4,
        REASON_ATTR_OVERRUN = 3'd5
    } reason_t;

    typedef enum logic [1:0] {
        HPOS_TYPE_HI = 2'd0,
        HPOS_TYPE_LO = 2'd1,
        HPOS_LEN_HI = 2'd2,
        HPOS_LEN_LO = 2'd3
    } hdr_pos_t;

    typedef struct packed {
        logic step;
        logic load;
        logic clear;
    } walk_ctrl_t;

endpackage

### sv/spv_if.sv
// Channel interfaces: payload bytes in, verdicts out.
interface spv_byte_if;
    logic valid;
    logic ready;
    logic [7:0] data_byte;
    logic last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface spv_verdict_if;
    logic valid;
    logic ready;
    logic is_stun;
    spv_pkg::reason_t reason;

    modport source (output valid, output is_stun, output reason, input ready);
    modport sink (input valid, input is_stun, input reason, output ready);
endinterface

### sv/spv_walker.sv
// Attribute header walk over the advertised message length.
module spv_walker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spv_pkg::walk_ctrl_t             ctrl,
    input  logic [7:0]                      data_byte,
    input  logic [spv_pkg::LEN_W-1:0]       load_len,
    output spv_pkg::reason_t                walk_error
);

    logic [spv_pkg::COUNT_W-1:0] remaining_reg, remaining_next;
    spv_pkg::hdr_pos_t           pos_reg, pos_next;
    logic [spv_pkg::LEN_W-1:0]   acc_reg, acc_next;
    logic [spv_pkg::COUNT_W-1:0] body_left_reg, body_left_next;
    spv_pkg::reason_t            error_reg, error_next;
    logic [spv_pkg::COUNT_W-1:0] remaining_dec;

    always_comb
    begin
        remaining_next = remaining_reg;
        pos_next = pos_reg;
        acc_next = acc_reg;
        body_left_next = body_left_reg;
        error_next = error_reg;
        remaining_dec = remaining_reg - 17'd1;

        if (ctrl.load)
        begin
            remaining_next = {1'b0, load_len};
        end
        else if (ctrl.step && error_reg == spv_pkg::REASON_OK && remaining_reg != '0)
        begin
            if (body_left_reg != '0)
            begin
                body_left_next = body_left_reg - 17'd1;
                remaining_next = remaining_dec;
            end
            else if (pos_reg == spv_pkg::HPOS_TYPE_HI
                     && remaining_reg < spv_pkg::ATTR_HDR_BYTES)
            begin
                error_next = spv_pkg::REASON_ATTR_TRUNC;
            end
            else
            begin
                if (pos_reg == spv_pkg::HPOS_LEN_HI)
                begin
                    acc_next = {data_byte, 8'h00};
                end
                else if (pos_reg == spv_pkg::HPOS_LEN_LO)
                begin
                    acc_next = {acc_reg[15:8], data_byte};
                end
                remaining_next = remaining_dec;
                if (pos_reg == spv_pkg::HPOS_LEN_LO)
                begin
                    pos_next = spv_pkg::HPOS_TYPE_HI;
                    if ({1'b0, acc_next} > remaining_dec)
                    begin
                        error_next = spv_pkg::REASON_ATTR_OVERRUN;
                    end
                    else
                    begin
                        body_left_next = {1'b0, acc_next};
                    end
                end
                else
                begin
                    pos_next = spv_pkg::hdr_pos_t'(pos_reg + 2'd1);
                end
            end
        end
    end

    assign walk_error = error_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            pos_reg <= spv_pkg::HPOS_TYPE_HI;
            acc_reg <= '0;
            body_left_reg <= '0;
            error_reg <= spv_pkg::REASON_OK;
        end
        else if (ctrl.clear)
        begin
            remaining_reg <= '0;
            pos_reg <= spv_pkg::HPOS_TYPE_HI;
            acc_reg <= '0;
            body_left_reg <= '0;
            error_reg <= spv_pkg::REASON_OK;
        end
        else
        begin
            remaining_reg <= remaining_next;
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            body_left_reg <= body_left_next;
            error_reg <= error_next;
        end
    end

endmodule

### sv/stun_packet_validator.sv
// Top level of the STUN packet validator: header checks and verdict register.
//
// The byte_in channel carries one UDP payload byte per item, in packet order,
// with last_byte marking the final byte of a packet. The verdict_out channel
// carries one item per packet: is_stun and a reason code (ok, short, bad
// cookie, length overrun, attribute truncated, attribute overrun).
// A new byte may be accepted every cycle while byte_in.ready is high.
// The verdict appears on verdict_out in the cycle after the last byte is
// accepted, held in a single output register. Bytes that are not last
// produce no verdict.
// byte_in.ready is high while the output register is empty or being drained,
// so a receiver stall holds up every input byte, last or not, as soon as a
// verdict is waiting in the output register.
// Reset clears the byte count, header fields, the attribute walk and the
// output valid; the next byte after reset or after any last byte starts a
// new packet. The byte count saturates on very long packets.
module stun_packet_validator (
    input  logic                  clk,
    input  logic                  rst_n,
    spv_byte_if.sink              byte_in,
    spv_verdict_if.source         verdict_out
);

    logic [spv_pkg::COUNT_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic [spv_pkg::LEN_W-1:0]   msg_len_reg, msg_len_next;
    logic [31:0]                 cookie_reg, cookie_next;
    logic                        out_valid_reg;
    logic                        is_stun_reg;
    spv_pkg::reason_t            reason_reg, reason_next;
    logic                        accept;
    spv_pkg::walk_ctrl_t         walk_ctrl;
    spv_pkg::reason_t            walk_error;

    assign byte_in.ready = !out_valid_reg || verdict_out.ready;
    assign accept = byte_in.valid && byte_in.ready;

    always_comb
    begin
        msg_len_next = msg_len_reg;
        cookie_next = cookie_reg;
        walk_ctrl = '0;
        if (bytes_seen_reg == spv_pkg::IDX_LEN_HI)
        begin
            msg_len_next = {byte_in.data_byte, 8'h00};
        end
        else if (bytes_seen_reg == spv_pkg::IDX_LEN_LO)
        begin
            msg_len_next = {msg_len_reg[15:8], byte_in.data_byte};
            walk_ctrl.load = accept;
        end
        else if (bytes_seen_reg >= spv_pkg::IDX_COOKIE_FIRST
                 && bytes_seen_reg < spv_pkg::IDX_COOKIE_END)
        begin
            cookie_next = {cookie_reg[23:0], byte_in.data_byte};
        end
        else if (bytes_seen_reg >= spv_pkg::HDR_BYTES)
        begin
            walk_ctrl.step = accept;
        end
        walk_ctrl.clear = accept && byte_in.last_byte;

        bytes_seen_next = (bytes_seen_reg < spv_pkg::COUNT_MAX)
                          ? bytes_seen_reg + 17'd1 : bytes_seen_reg;

        if (bytes_seen_next < spv_pkg::HDR_BYTES)
        begin
            reason_next = spv_pkg::REASON_SHORT;
        end
        else if (cookie_next != spv_pkg::MAGIC_COOKIE)
        begin
            reason_next = spv_pkg::REASON_BAD_COOKIE;
        end
        else if ({1'b0, msg_len_next} > bytes_seen_next - spv_pkg::HDR_BYTES)
        begin
            reason_next = spv_pkg::REASON_LEN_OVERRUN;
        end
        else
        begin
            reason_next = walk_error;
        end
    end

    spv_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (walk_ctrl),
        .data_byte  (byte_in.data_byte),
        .load_len   (msg_len_next),
        .walk_error (walk_error)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            msg_len_reg <= '0;
            cookie_reg <= '0;
        end
        else if (accept)
        begin
            if (byte_in.last_byte)
            begin
                bytes_seen_reg <= '0;
                msg_len_reg <= '0;
                cookie_reg <= '0;
            end
            else
            begin
                bytes_seen_reg <= bytes_seen_next;
                msg_len_reg <= msg_len_next;
                cookie_reg <= cookie_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && byte_in.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (verdict_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && byte_in.last_byte)
        begin
            is_stun_reg <= (reason_next == spv_pkg::REASON_OK);
            reason_reg <= reason_next;
        end
    end

    assign verdict_out.valid = out_valid_reg;
    assign verdict_out.is_stun = is_stun_reg;
    assign verdict_out.reason = reason_reg;

endmodule
